/* hdl/pidc_pkg.sv */
`default_nettype none

package pidc_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned GAIN_W  = 24;
  localparam int unsigned FRAC_W  = 12;
  localparam int unsigned ERR_W   = DATA_W + 1;
  localparam int unsigned DER_W   = ERR_W + 1;
  localparam int unsigned PROD_W  = GAIN_W + 1 + ERR_W;
  localparam int unsigned DPROD_W = GAIN_W + 1 + DER_W;
  localparam int unsigned PTERM_W = PROD_W - FRAC_W;
  localparam int unsigned DTERM_W = DPROD_W - FRAC_W;
  localparam int unsigned SUM_W   = DTERM_W + 2;
  localparam int          HALF_LSB = 1 << (FRAC_W - 1);

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic signed [DATA_W-1:0] OUT_MIN_RST = 32'sh0000_0000;
  localparam logic signed [DATA_W-1:0] OUT_MAX_RST = 32'sh0FFF_F000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP        = 3'd0,
    REG_KI        = 3'd1,
    REG_KD        = 3'd2,
    REG_OUT_MIN   = 3'd3,
    REG_OUT_MAX   = 3'd4,
    REG_AUTO_MODE = 3'd5
  } pidc_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } pidc_gains_t;

  // below lo gives lo, else above hi gives hi
  function automatic logic signed [DATA_W-1:0] pidc_clamp(
    input logic signed [SUM_W-1:0]  x,
    input logic signed [DATA_W-1:0] lo,
    input logic signed [DATA_W-1:0] hi
  );
    logic signed [SUM_W-1:0] lo_x;
    logic signed [SUM_W-1:0] hi_x;
    lo_x = SUM_W'(lo);
    hi_x = SUM_W'(hi);
    if (x < lo_x) begin
      return lo;
    end else if (x > hi_x) begin
      return hi;
    end else begin
      return x[DATA_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* hdl/pidc_gain.sv */
`default_nettype none

module pidc_gain import pidc_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire pidc_gains_t                gains_i,
  input  wire logic signed [ERR_W-1:0]    err_i,
  input  wire logic signed [DER_W-1:0]    der_i,
  output      logic signed [PTERM_W-1:0]  pterm_o,
  output      logic signed [PTERM_W-1:0]  iterm_o,
  output      logic signed [DTERM_W-1:0]  dterm_o
);

  logic signed [PROD_W-1:0]  p_prod, i_prod, p_rnd, i_rnd;
  logic signed [DPROD_W-1:0] d_prod, d_rnd;
  logic signed [PTERM_W-1:0] pterm_q, iterm_q;
  logic signed [DTERM_W-1:0] dterm_q;

  assign p_prod = PROD_W'($signed({1'b0, gains_i.kp})) * PROD_W'(err_i);
  assign i_prod = PROD_W'($signed({1'b0, gains_i.ki})) * PROD_W'(err_i);
  assign d_prod = DPROD_W'($signed({1'b0, gains_i.kd})) * DPROD_W'(der_i);

  // round half up, then floor shift back to Q.12
  assign p_rnd = p_prod + PROD_W'(HALF_LSB);
  assign i_rnd = i_prod + PROD_W'(HALF_LSB);
  assign d_rnd = d_prod + DPROD_W'(HALF_LSB);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pterm_q <= p_rnd[PROD_W-1:FRAC_W];
      iterm_q <= i_rnd[PROD_W-1:FRAC_W];
      dterm_q <= d_rnd[DPROD_W-1:FRAC_W];
    end
  end

  assign pterm_o = pterm_q;
  assign iterm_o = iterm_q;
  assign dterm_o = dterm_q;

endmodule

`default_nettype wire

/* hdl/pid_controller_clamped.sv */
// Clamped PID controller in fixed point. One sample (target, actual; signed Q20.12) per
// input beat gives one result beat: drive in tdata and valid_res in tuser. The block takes
// one sample per cycle unless m_axis_tready stalls the output; each result passes the five
// pipeline registers (input, error, gain products, integral, output). The integral update
// closes in a single stage, so back-to-back samples need no gaps. The user must write gains
// and limits via the cfg channel (index 0 kp, 1 ki, 2 kd, 3 out_min, 4 out_max, 5 auto_mode)
// only while no sample is in flight; the block does not enforce this. cfg_ready_o is always
// high. In manual mode results carry drive 0 and valid_res 0; controller state is untouched.
`default_nettype none

module pid_controller_clamped import pidc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  input  wire logic [2*DATA_W-1:0]   s_axis_tdata,   // target, actual
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output      logic [DATA_W-1:0]     m_axis_tdata,   // drive
  output      logic                  m_axis_tuser,   // valid_res
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [DATA_W-1:0]     cfg_data_i
);

  pidc_gains_t               gains_q;
  logic signed [DATA_W-1:0]  out_min_q, out_max_q;
  logic                      auto_q;
  logic signed [DATA_W-1:0]  integral_q;
  logic signed [ERR_W-1:0]   perr_q;
  logic                      perr_vld_q;

  logic v1_q, v2_q, v3_q, v4_q, out_vld_q;
  logic a1_q, a2_q, a3_q, a4_q, vres_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic acc, adv1, adv2, adv3, adv4;

  logic signed [DATA_W-1:0]  tgt1_q, act1_q;
  logic signed [ERR_W-1:0]   err_c, err2_q;
  logic signed [DER_W-1:0]   der_c, der2_q;
  logic signed [PTERM_W-1:0] pterm, iterm, p4_q;
  logic signed [DTERM_W-1:0] dterm, d4_q;
  logic signed [DATA_W-1:0]  drive_q, drive_c, integral_c;

  logic                      cfg_we;
  pidc_reg_e                 cfg_reg;
  logic                      int_cfg_upd, enter_auto;
  logic signed [DATA_W-1:0]  int_cfg_val;

  // ---------------- handshake chain ----------------
  assign rdy5 = !out_vld_q || m_axis_tready;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign adv4 = v4_q && rdy5;
  assign adv3 = v3_q && rdy4;
  assign adv2 = v2_q && rdy3;
  assign adv1 = v1_q && rdy2;
  assign acc  = s_axis_tvalid && rdy1;

  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = drive_q;
  assign m_axis_tuser  = vres_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      v1_q      <= acc  || (v1_q && !adv1);
      v2_q      <= adv1 || (v2_q && !adv2);
      v3_q      <= adv2 || (v3_q && !adv3);
      v4_q      <= adv3 || (v4_q && !adv4);
      out_vld_q <= adv4 || (out_vld_q && !m_axis_tready);
    end
  end

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign cfg_reg     = pidc_reg_e'(cfg_index_i);

  always_comb begin
    int_cfg_upd = 1'b0;
    enter_auto  = 1'b0;
    int_cfg_val = integral_q;
    case (cfg_reg)
      REG_OUT_MIN: begin
        int_cfg_upd = auto_q;
        int_cfg_val = pidc_clamp(SUM_W'(integral_q), $signed(cfg_data_i), out_max_q);
      end
      REG_OUT_MAX: begin
        int_cfg_upd = auto_q;
        int_cfg_val = pidc_clamp(SUM_W'(integral_q), out_min_q, $signed(cfg_data_i));
      end
      REG_AUTO_MODE: begin
        enter_auto  = cfg_data_i[0] && !auto_q;
        int_cfg_upd = enter_auto;
        int_cfg_val = pidc_clamp('0, out_min_q, out_max_q);
      end
      default: begin
        int_cfg_upd = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q   <= '0;
      out_min_q <= OUT_MIN_RST;
      out_max_q <= OUT_MAX_RST;
      auto_q    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg)
        REG_KP:        gains_q.kp <= cfg_data_i[GAIN_W-1:0];
        REG_KI:        gains_q.ki <= cfg_data_i[GAIN_W-1:0];
        REG_KD:        gains_q.kd <= cfg_data_i[GAIN_W-1:0];
        REG_OUT_MIN:   out_min_q  <= $signed(cfg_data_i);
        REG_OUT_MAX:   out_max_q  <= $signed(cfg_data_i);
        REG_AUTO_MODE: auto_q     <= cfg_data_i[0];
        default:       auto_q     <= auto_q;
      endcase
    end
  end

  // ---------------- stage 1: input register ----------------
  always_ff @(posedge clk_i) begin
    if (acc) begin
      tgt1_q <= $signed(s_axis_tdata[DATA_W-1:0]);
      act1_q <= $signed(s_axis_tdata[2*DATA_W-1:DATA_W]);
      a1_q   <= auto_q;
    end
  end

  // ---------------- stage 2: error and change in error ----------------
  assign err_c = ERR_W'(tgt1_q) - ERR_W'(act1_q);
  assign der_c = perr_vld_q ? (DER_W'(err_c) - DER_W'(perr_q)) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      perr_q     <= '0;
      perr_vld_q <= 1'b0;
    end else if (cfg_we && enter_auto) begin
      perr_vld_q <= 1'b0;
    end else if (adv1 && a1_q) begin
      perr_q     <= err_c;
      perr_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      err2_q <= err_c;
      der2_q <= der_c;
      a2_q   <= a1_q;
    end
  end

  // ---------------- stage 3: gain products ----------------
  pidc_gain u_gain (
    .clk_i   (clk_i),
    .en_i    (adv2),
    .gains_i (gains_q),
    .err_i   (err2_q),
    .der_i   (der2_q),
    .pterm_o (pterm),
    .iterm_o (iterm),
    .dterm_o (dterm)
  );

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      a3_q <= a2_q;
    end
  end

  // ---------------- stage 4: integral ----------------
  assign integral_c = pidc_clamp(SUM_W'(integral_q) + SUM_W'(iterm), out_min_q, out_max_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q <= '0;
    end else if (cfg_we && int_cfg_upd) begin
      integral_q <= int_cfg_val;
    end else if (adv3 && a3_q) begin
      integral_q <= integral_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      p4_q <= pterm;
      d4_q <= dterm;
      a4_q <= a3_q;
    end
  end

  // ---------------- stage 5: output ----------------
  assign drive_c = pidc_clamp(SUM_W'(p4_q) + SUM_W'(integral_q) - SUM_W'(d4_q),
                              out_min_q, out_max_q);

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      drive_q <= a4_q ? drive_c : '0;
      vres_q  <= a4_q;
    end
  end

endmodule

`default_nettype wire

/* hdl/pidc_checker.sv */
`default_nettype none

module pidc_checker import pidc_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [DATA_W-1:0]     m_axis_tdata,
  input wire logic                  m_axis_tuser,
  input wire logic                  cfg_valid_i,
  input wire logic                  cfg_ready_o,
  input wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input wire logic [DATA_W-1:0]     cfg_data_i
);

  logic signed [DATA_W-1:0] min_q, max_q;
  logic                     cfg_beat;

  assign cfg_beat = cfg_valid_i && cfg_ready_o;

  // shadow copy of the limits as seen on the cfg port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= OUT_MIN_RST;
      max_q <= OUT_MAX_RST;
    end else if (cfg_beat) begin
      if (pidc_reg_e'(cfg_index_i) == REG_OUT_MIN) begin
        min_q <= $signed(cfg_data_i);
      end
      if (pidc_reg_e'(cfg_index_i) == REG_OUT_MAX) begin
        max_q <= $signed(cfg_data_i);
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  a_manual_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("manual-mode beat with nonzero drive");

  a_in_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser && (min_q <= max_q) |->
      ($signed(m_axis_tdata) >= min_q) && ($signed(m_axis_tdata) <= max_q))
    else $error("drive outside limits");

  a_ready_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind pid_controller_clamped pidc_checker u_pidc_checker (.*);

`default_nettype wire
